### hdl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg: shared types and constants of the voice allocator
// Field widths, action and event codes, register indexes and reset values,
// sequencer states and the flag bundle of the slot evaluation unit.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Default sizing
  localparam int VOICE_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;

  // Fixed field widths
  localparam int ACT_W   = 2;
  localparam int NOW_W   = 48;
  localparam int CH_W    = 4;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int DUR_W   = 32;
  localparam int KIND_W  = 2;
  localparam int LIM_W   = 6;
  localparam int CFG_IDX_W = 2;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_NOTE_ON = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ALL_OFF = 2'd2;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_NOTE_OFF = 2'd0;
  localparam logic [KIND_W-1:0] EV_NOTE_ON  = 2'd1;
  localparam logic [KIND_W-1:0] EV_DONE     = 2'd2;

  // Configuration registers
  localparam logic [CFG_IDX_W-1:0] REG_PER_CHANNEL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_LIMIT      = 2'd1;
  localparam logic [LIM_W-1:0]     PER_CHANNEL_LIMIT_RST = 6'd4;
  localparam logic [LIM_W-1:0]     GLOBAL_LIMIT_RST      = 6'd16;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_STEAL  = 7'b0001000,
    ST_SCANG  = 7'b0010000,
    ST_STORE  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  // Comparator use of the evaluation unit
  typedef enum logic {
    EVAL_OLDEST = 1'b0,
    EVAL_EXPIRE = 1'b1
  } eval_mode_t;

  // Flags of one evaluated slot
  typedef struct packed {
    logic ch_match;
    logic key_match;
    logic lt;
  } eval_flags_t;

endpackage

### hdl/pva_ram.sv
// ----------------------------------------------------------------------------
// pva_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/pva_eval.sv
// ----------------------------------------------------------------------------
// pva_eval: slot evaluation unit
// Matches one slot against the request and runs the single shared
// time comparator, used for age ordering and for expiry checks.
// ----------------------------------------------------------------------------
module pva_eval #(
  parameter int TIME_BITS = pva_pkg::TIME_BITS_DEF
) (
  input  pva_pkg::eval_mode_t          mode,
  input  logic [pva_pkg::CH_W-1:0]     req_channel,
  input  logic [pva_pkg::NOTE_W-1:0]   req_note,
  input  logic [TIME_BITS-1:0]         now_t,
  input  logic [TIME_BITS-1:0]         best_start,
  input  logic [pva_pkg::CH_W-1:0]     slot_channel,
  input  logic [pva_pkg::NOTE_W-1:0]   slot_note,
  input  logic [TIME_BITS-1:0]         slot_start,
  input  logic [TIME_BITS:0]           slot_end,
  output pva_pkg::eval_flags_t         flags
);

  logic [TIME_BITS:0] lhs;
  logic [TIME_BITS:0] rhs;

  // Operand select: expiry tests now < end, age tests start < best
  always_comb begin
    if (mode == pva_pkg::EVAL_EXPIRE) begin
      lhs = {1'b0, now_t};
      rhs = slot_end;
    end else begin
      lhs = {1'b0, slot_start};
      rhs = {1'b0, best_start};
    end
  end

  assign flags.lt        = (lhs < rhs);
  assign flags.ch_match  = (slot_channel == req_channel);
  assign flags.key_match = (slot_channel == req_channel) && (slot_note == req_note);

endmodule

### hdl/polyphonic_voice_allocator_top.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_top: voice slot allocator with oldest steal
// Keeps a table of voice slots, handles note_on, tick and all_off items
// and emits note-off, note-on and done events.
//
//   Channel | Handshake          | Carries
//   --------+--------------------+---------------------------------------
//   in      | in_valid/in_stall  | action, now_ms, channel, note_number,
//           |                    | velocity, duration_ms
//   out     | out_valid/out_stall| event_kind, event_channel, event_note,
//           |                    | event_velocity, status, last
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item at a time; a scan walks the slot RAM one slot per cycle while
// no release event waits on out_stall. A note_on item adds decide and
// store steps, a steal at the channel limit and a second scan over all
// slots with a steal at the global limit. A waiting event held by
// out_stall also stalls the steal, store and done steps.
// Reset clears slot activity and restores the default limits.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_top #(
  parameter int VOICE_SLOTS = pva_pkg::VOICE_SLOTS_DEF,
  parameter int TIME_BITS   = pva_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pva_pkg::ACT_W-1:0]        action,
  input  logic [pva_pkg::NOW_W-1:0]        now_ms,
  input  logic [pva_pkg::CH_W-1:0]         channel,
  input  logic [pva_pkg::NOTE_W-1:0]       note_number,
  input  logic [pva_pkg::VEL_W-1:0]        velocity,
  input  logic [pva_pkg::DUR_W-1:0]        duration_ms,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pva_pkg::KIND_W-1:0]       event_kind,
  output logic [pva_pkg::CH_W-1:0]         event_channel,
  output logic [pva_pkg::NOTE_W-1:0]       event_note,
  output logic [pva_pkg::VEL_W-1:0]        event_velocity,
  output logic                             status,
  output logic                             last,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pva_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pva_pkg::LIM_W-1:0]        cfg_data
);

  localparam int IDX_W  = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(VOICE_SLOTS + 1);
  localparam int END_W  = TIME_BITS + 1;
  localparam int WORD_W = pva_pkg::CH_W + pva_pkg::NOTE_W + TIME_BITS + END_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_SLOTS - 1);

  // Sequencer and slot state
  pva_pkg::state_t             state, state_next;
  logic [IDX_W-1:0]            idx, idx_next;
  logic [VOICE_SLOTS-1:0]      active, active_next;

  // Captured request
  logic [pva_pkg::ACT_W-1:0]   req_action;
  logic [TIME_BITS-1:0]        req_now;
  logic [pva_pkg::CH_W-1:0]    req_ch;
  logic [pva_pkg::NOTE_W-1:0]  req_note;
  logic [pva_pkg::VEL_W-1:0]   req_vel;
  logic [pva_pkg::DUR_W-1:0]   req_dur;

  // Scan results
  logic [CNT_W-1:0]            total, total_next;
  logic [CNT_W-1:0]            chcnt, chcnt_next;
  logic                        best_found, best_found_next;
  logic [IDX_W-1:0]            best_idx, best_idx_next;
  logic [TIME_BITS-1:0]        best_start, best_start_next;
  logic [pva_pkg::CH_W-1:0]    best_ch, best_ch_next;
  logic [pva_pkg::NOTE_W-1:0]  best_note, best_note_next;
  logic                        steal_global, steal_global_next;
  logic                        free_found, free_found_next;
  logic [IDX_W-1:0]            free_idx, free_idx_next;
  logic                        status_flag, status_flag_next;

  // Limits
  logic [pva_pkg::LIM_W-1:0]   per_channel_limit;
  logic [pva_pkg::LIM_W-1:0]   global_limit;

  // Slot RAM
  logic                        ram_we;
  logic [IDX_W-1:0]            wr_idx;
  logic [WORD_W-1:0]           wr_word;
  logic [WORD_W-1:0]           rd_word;
  logic [pva_pkg::CH_W-1:0]    slot_ch;
  logic [pva_pkg::NOTE_W-1:0]  slot_note;
  logic [TIME_BITS-1:0]        slot_start;
  logic [END_W-1:0]            slot_end;

  // Evaluation unit
  pva_pkg::eval_mode_t         eval_mode;
  pva_pkg::eval_flags_t        flags;

  // Output staging
  logic                        can_emit;
  logic                        emit;
  logic [pva_pkg::KIND_W-1:0]  emit_kind;
  logic [pva_pkg::CH_W-1:0]    emit_ch;
  logic [pva_pkg::NOTE_W-1:0]  emit_note;
  logic [pva_pkg::VEL_W-1:0]   emit_vel;
  logic                        emit_status;
  logic                        emit_last;

  // Lowest free slot
  logic                        penc_found;
  logic [IDX_W-1:0]            penc_idx;

  logic                        in_accept;
  logic                        is_note_on;
  logic                        slot_act;
  logic                        release_hit;
  logic                        store_found;
  logic [IDX_W-1:0]            store_idx;
  logic                        ch_over;
  logic                        gl_over;

  assign in_stall   = (state != pva_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cfg_ready  = 1'b1;
  assign can_emit   = !out_valid || !out_stall;
  assign is_note_on = (req_action == pva_pkg::ACT_NOTE_ON);
  assign slot_act   = active[idx];
  assign ch_over    = (pva_pkg::LIM_W'(chcnt) >= per_channel_limit);
  assign gl_over    = (pva_pkg::LIM_W'(total) >= global_limit);

  // Slot word layout: channel, note, start time, end time
  assign slot_end   = rd_word[END_W-1:0];
  assign slot_start = rd_word[END_W +: TIME_BITS];
  assign slot_note  = rd_word[END_W + TIME_BITS +: pva_pkg::NOTE_W];
  assign slot_ch    = rd_word[END_W + TIME_BITS + pva_pkg::NOTE_W +: pva_pkg::CH_W];
  assign wr_word    = {req_ch, req_note, req_now,
                       END_W'(req_now) + END_W'(req_dur)};

  pva_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VOICE_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_idx),
    .wr_data (wr_word),
    .rd_addr (idx_next),
    .rd_data (rd_word)
  );

  assign eval_mode = ((state == pva_pkg::ST_SCAN) && (req_action == pva_pkg::ACT_TICK))
                     ? pva_pkg::EVAL_EXPIRE : pva_pkg::EVAL_OLDEST;

  pva_eval #(
    .TIME_BITS (TIME_BITS)
  ) u_eval (
    .mode         (eval_mode),
    .req_channel  (req_ch),
    .req_note     (req_note),
    .now_t        (req_now),
    .best_start   (best_start),
    .slot_channel (slot_ch),
    .slot_note    (slot_note),
    .slot_start   (slot_start),
    .slot_end     (slot_end),
    .flags        (flags)
  );

  // Lowest inactive slot
  always_comb begin
    penc_found = 1'b0;
    penc_idx   = '0;
    for (int i = VOICE_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        penc_found = 1'b1;
        penc_idx   = IDX_W'(i);
      end
    end
  end

  // Release condition of the first scan
  always_comb begin
    case (req_action)
      pva_pkg::ACT_NOTE_ON: release_hit = slot_act && flags.key_match;
      pva_pkg::ACT_TICK:    release_hit = slot_act && !flags.lt;
      pva_pkg::ACT_ALL_OFF: release_hit = slot_act;
      default:              release_hit = 1'b0;
    endcase
  end

  assign store_found = free_found || penc_found;
  assign store_idx   = free_found ? free_idx : penc_idx;

  // Sequencer
  always_comb begin
    state_next        = state;
    idx_next          = '0;
    active_next       = active;
    total_next        = total;
    chcnt_next        = chcnt;
    best_found_next   = best_found;
    best_idx_next     = best_idx;
    best_start_next   = best_start;
    best_ch_next      = best_ch;
    best_note_next    = best_note;
    steal_global_next = steal_global;
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    status_flag_next  = status_flag;
    ram_we            = 1'b0;
    wr_idx            = store_idx;
    emit              = 1'b0;
    emit_kind         = pva_pkg::EV_NOTE_OFF;
    emit_ch           = slot_ch;
    emit_note         = slot_note;
    emit_vel          = '0;
    emit_status       = 1'b0;
    emit_last         = 1'b0;

    case (state)
      pva_pkg::ST_IDLE: begin
        if (in_accept) begin
          total_next       = '0;
          chcnt_next       = '0;
          best_found_next  = 1'b0;
          free_found_next  = 1'b0;
          status_flag_next = 1'b0;
          if (action inside {pva_pkg::ACT_NOTE_ON, pva_pkg::ACT_TICK,
                             pva_pkg::ACT_ALL_OFF}) begin
            state_next = pva_pkg::ST_SCAN;
          end else begin
            state_next = pva_pkg::ST_DONE;
          end
        end
      end

      // Retrigger, count and channel-oldest pass, or expiry / all-off pass
      pva_pkg::ST_SCAN: begin
        if (release_hit && !can_emit) begin
          idx_next = idx;
        end else begin
          if (release_hit) begin
            emit             = 1'b1;
            active_next[idx] = 1'b0;
          end else if (is_note_on && slot_act) begin
            total_next = total + CNT_W'(1);
            if (flags.ch_match) begin
              chcnt_next = chcnt + CNT_W'(1);
              if (!best_found || flags.lt) begin
                best_found_next = 1'b1;
                best_idx_next   = idx;
                best_start_next = slot_start;
                best_ch_next    = slot_ch;
                best_note_next  = slot_note;
              end
            end
          end
          if (idx == LAST_IDX) begin
            state_next = is_note_on ? pva_pkg::ST_DECIDE : pva_pkg::ST_DONE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end

      pva_pkg::ST_DECIDE: begin
        free_found_next = penc_found;
        free_idx_next   = penc_idx;
        if (ch_over) begin
          steal_global_next = 1'b0;
          state_next        = pva_pkg::ST_STEAL;
        end else if (gl_over) begin
          steal_global_next = 1'b1;
          best_found_next   = 1'b0;
          state_next        = pva_pkg::ST_SCANG;
        end else begin
          state_next = pva_pkg::ST_STORE;
        end
      end

      // Release the victim held in the best registers, if any
      pva_pkg::ST_STEAL: begin
        if (!best_found || can_emit) begin
          if (best_found) begin
            emit                  = 1'b1;
            emit_ch               = best_ch;
            emit_note             = best_note;
            active_next[best_idx] = 1'b0;
          end
          if (!steal_global && gl_over) begin
            steal_global_next = 1'b1;
            best_found_next   = 1'b0;
            state_next        = pva_pkg::ST_SCANG;
          end else begin
            state_next = pva_pkg::ST_STORE;
          end
        end
      end

      // Oldest voice over all channels
      pva_pkg::ST_SCANG: begin
        if (slot_act && (!best_found || flags.lt)) begin
          best_found_next = 1'b1;
          best_idx_next   = idx;
          best_start_next = slot_start;
          best_ch_next    = slot_ch;
          best_note_next  = slot_note;
        end
        if (idx == LAST_IDX) begin
          state_next = pva_pkg::ST_STEAL;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end

      pva_pkg::ST_STORE: begin
        if (!store_found) begin
          status_flag_next = 1'b1;
          state_next       = pva_pkg::ST_DONE;
        end else if (can_emit) begin
          emit                   = 1'b1;
          emit_kind              = pva_pkg::EV_NOTE_ON;
          emit_ch                = req_ch;
          emit_note              = req_note;
          emit_vel               = req_vel;
          ram_we                 = 1'b1;
          active_next[store_idx] = 1'b1;
          state_next             = pva_pkg::ST_DONE;
        end
      end

      pva_pkg::ST_DONE: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_kind   = pva_pkg::EV_DONE;
          emit_ch     = '0;
          emit_note   = '0;
          emit_status = status_flag;
          emit_last   = 1'b1;
          state_next  = pva_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = pva_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pva_pkg::ST_IDLE;
      idx    <= '0;
      active <= '0;
    end else begin
      state  <= state_next;
      idx    <= idx_next;
      active <= active_next;
    end
  end

  // Request capture and scan results
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_action <= action;
      req_now    <= TIME_BITS'(now_ms);
      req_ch     <= channel;
      req_note   <= note_number;
      req_vel    <= velocity;
      req_dur    <= duration_ms;
    end
    total        <= total_next;
    chcnt        <= chcnt_next;
    best_found   <= best_found_next;
    best_idx     <= best_idx_next;
    best_start   <= best_start_next;
    best_ch      <= best_ch_next;
    best_note    <= best_note_next;
    steal_global <= steal_global_next;
    free_found   <= free_found_next;
    free_idx     <= free_idx_next;
    status_flag  <= status_flag_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      per_channel_limit <= pva_pkg::PER_CHANNEL_LIMIT_RST;
      global_limit      <= pva_pkg::GLOBAL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pva_pkg::REG_PER_CHANNEL_LIMIT: per_channel_limit <= cfg_data;
        pva_pkg::REG_GLOBAL_LIMIT:      global_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind     <= emit_kind;
      event_channel  <= emit_ch;
      event_note     <= emit_note;
      event_velocity <= emit_vel;
      status         <= emit_status;
      last           <= emit_last;
    end
  end

  // Checks
  a_one_voice_added: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(active) <= $countones($past(active)) + 1)
    else $error("more than one voice started in a cycle");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> event_kind == pva_pkg::EV_DONE)
    else $error("last flag on an event that is not done");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != pva_pkg::ST_IDLE)
    else $error("sequencer idle after accepting an item");

  a_store_free_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !active[wr_idx])
    else $error("note stored over an active slot");

endmodule
